// File: rtl/dtcsm_pkg.sv
// Shared types and constants of the trouble code status manager.
`timescale 1ns / 1ps

package dtcsm_pkg;

  // Table geometry
  localparam int NumEntriesDefault = 32;

  // Operation codes
  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_CYCLE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Outcome codes
  localparam logic [1:0] OUT_APPLIED = 2'd0;
  localparam logic [1:0] OUT_RANGE   = 2'd1;
  localparam logic [1:0] OUT_BLOCKED = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_UPDATES_OFF  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_EXC_BATT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BATT_UNDER   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BATT_OVER    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FAULT_MAX    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FAULT_MIN    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_AGING_MAX    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_AVAIL_MASK   = 3'd7;

  // Status byte bit positions
  localparam int StTf    = 0;  // testFailed
  localparam int StTftoc = 1;  // testFailedThisOperationCycle
  localparam int StPend  = 2;  // pendingDTC
  localparam int StConf  = 3;  // confirmedDTC
  localparam int StTnclc = 4;  // testNotCompletedSinceLastClear
  localparam int StTfslc = 5;  // testFailedSinceLastClear
  localparam int StTnctoc = 6; // testNotCompletedThisOperationCycle

  localparam logic [7:0] STATUS_CLEARED = 8'h50;
  localparam logic [7:0] AGING_AT_RESET = 8'd1;

  // One table entry as kept in the memory
  typedef struct packed {
    logic [7:0]        status;
    logic signed [7:0] fault;
    logic [7:0]        aging;
  } entry_t;

endpackage

// File: rtl/dtc_status_manager.sv
// Top level of the trouble code status manager: table memory and update logic.
`timescale 1ns / 1ps

// Keeps NUM_ENTRIES trouble code entries (status byte, signed fault counter,
// aging counter) in one synchronous memory and applies one operation per
// input transfer: test report, operation cycle start, clear or status read.
// The entry is read from the memory into a register when the item is taken;
// in the update step it is updated, written back when applied and placed in
// the output register, and only then is the next item taken. A result waiting
// in the output register holds the block in its update step until it is taken;
// a finished result does not block the next item's transfer. Entries come out
// of reset as status 0x50, fault counter 0, aging counter 1, through a valid
// bit per entry, so no clearing pass is needed. Configuration writes are
// taken at any time but are meant for idle periods only.
module dtc_status_manager #(
  parameter int NUM_ENTRIES = dtcsm_pkg::NumEntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [dtcsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [7:0]                     entry_index_i,
  input  logic                           test_failed_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     outcome_o,
  output logic [7:0]                     status_byte_o,
  output logic [7:0]                     available_status_o,
  output logic signed [7:0]              fault_count_o,
  output logic [7:0]                     aging_count_o
);

  localparam int AddrW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [8:0] NumEntriesW = 9'(NUM_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  // Configuration registers
  logic              updates_off_q;
  logic              off_exc_batt_q;
  logic [7:0]        batt_under_q;
  logic [7:0]        batt_over_q;
  logic [6:0]        fault_max_q;
  logic signed [7:0] fault_min_q;
  logic [7:0]        aging_max_q;
  logic [7:0]        avail_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      updates_off_q  <= 1'b0;
      off_exc_batt_q <= 1'b0;
      batt_under_q   <= 8'd0;
      batt_over_q    <= 8'd1;
      fault_max_q    <= 7'd127;
      fault_min_q    <= -8'sd128;
      aging_max_q    <= 8'd40;
      avail_mask_q   <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtcsm_pkg::REG_UPDATES_OFF:  updates_off_q  <= cfg_wdata_i[0];
        dtcsm_pkg::REG_OFF_EXC_BATT: off_exc_batt_q <= cfg_wdata_i[0];
        dtcsm_pkg::REG_BATT_UNDER:   batt_under_q   <= cfg_wdata_i;
        dtcsm_pkg::REG_BATT_OVER:    batt_over_q    <= cfg_wdata_i;
        dtcsm_pkg::REG_FAULT_MAX:    fault_max_q    <= cfg_wdata_i[6:0];
        dtcsm_pkg::REG_FAULT_MIN:    fault_min_q    <= $signed(cfg_wdata_i);
        dtcsm_pkg::REG_AGING_MAX:    aging_max_q    <= cfg_wdata_i;
        dtcsm_pkg::REG_AVAIL_MASK:   avail_mask_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state
  logic state_q, state_d;
  logic out_valid_q;
  logic in_xfer, out_load, mem_we;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_CALC) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CALC;
      ST_CALC: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Item registers, captured on input transfer
  logic [1:0] op_q;
  logic [7:0] idx_q;
  logic       failed_q;
  logic       in_range_q;
  logic       in_range;

  assign in_range = ({1'b0, entry_index_i} < NumEntriesW);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= opcode_i;
      idx_q      <= entry_index_i;
      failed_q   <= test_failed_i;
      in_range_q <= in_range;
    end
  end

  // Entry memory with registered read; valid bits mark written entries
  dtcsm_pkg::entry_t mem_q [NUM_ENTRIES];
  dtcsm_pkg::entry_t rdata_q;
  dtcsm_pkg::entry_t wdata;
  logic [NUM_ENTRIES-1:0] ent_vld_q;
  logic                   rd_vld_q;
  logic [AddrW-1:0]       rd_addr, wr_addr;

  assign rd_addr = entry_index_i[AddrW-1:0];
  assign wr_addr = idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wdata;
    if (in_xfer) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) ent_vld_q[wr_addr] <= 1'b1;
      if (in_xfer) rd_vld_q <= in_range & ent_vld_q[rd_addr];
    end
  end

  // Update logic
  dtcsm_pkg::entry_t cur, nxt;
  logic [1:0]        outcome;
  logic              blocked;

  always_comb begin
    logic signed [7:0] fmax_s;
    logic signed [8:0] sum;
    logic signed [7:0] cnew;
    logic [7:0]        st;

    fmax_s = $signed({1'b0, fault_max_q});
    sum    = '0;
    cnew   = '0;

    if (rd_vld_q) begin
      cur = rdata_q;
    end else begin
      cur.status = dtcsm_pkg::STATUS_CLEARED;
      cur.fault  = '0;
      cur.aging  = dtcsm_pkg::AGING_AT_RESET;
    end
    nxt = cur;
    st  = cur.status;

    blocked = (op_q == dtcsm_pkg::OP_REPORT) &
              (updates_off_q |
               (off_exc_batt_q & (idx_q != batt_under_q) & (idx_q != batt_over_q)));

    if (blocked) outcome = dtcsm_pkg::OUT_BLOCKED;
    else if (!in_range_q) outcome = dtcsm_pkg::OUT_RANGE;
    else outcome = dtcsm_pkg::OUT_APPLIED;

    case (op_q)
      dtcsm_pkg::OP_REPORT: begin
        if (failed_q) begin
          if (cur.fault < fmax_s) begin
            if (cur.fault[7]) begin
              cnew = 8'sd1;
            end else begin
              sum  = {cur.fault[7], cur.fault} + 9'sd2;
              cnew = (sum > 9'sd127) ? 8'sd127 : sum[7:0];
            end
            if (cnew >= fmax_s) begin
              st[dtcsm_pkg::StTf]     = 1'b1;
              st[dtcsm_pkg::StTftoc]  = 1'b1;
              st[dtcsm_pkg::StPend]   = 1'b1;
              st[dtcsm_pkg::StConf]   = 1'b1;
              st[dtcsm_pkg::StTfslc]  = 1'b1;
              st[dtcsm_pkg::StTnclc]  = 1'b0;
              st[dtcsm_pkg::StTnctoc] = 1'b0;
            end
            nxt.fault = cnew;
          end
        end else begin
          if (cur.fault > fault_min_q) begin
            cnew = cur.fault - 8'sd1;
            if (cnew <= fault_min_q) begin
              st[dtcsm_pkg::StTf]     = 1'b0;
              st[dtcsm_pkg::StTnclc]  = 1'b0;
              st[dtcsm_pkg::StTnctoc] = 1'b0;
            end
            nxt.fault = cnew;
          end
        end
        nxt.status = st;
      end
      dtcsm_pkg::OP_CYCLE: begin
        // age a clean entry, restart aging after a failing cycle
        if (!st[dtcsm_pkg::StTftoc]) begin
          st[dtcsm_pkg::StPend] = 1'b0;
          if (cur.aging < aging_max_q) nxt.aging = cur.aging + 8'd1;
          else st[dtcsm_pkg::StConf] = 1'b0;
        end else begin
          nxt.aging = '0;
        end
        st[dtcsm_pkg::StTftoc]  = 1'b0;
        st[dtcsm_pkg::StTnctoc] = 1'b1;
        nxt.status = st;
        nxt.fault  = '0;
      end
      dtcsm_pkg::OP_CLEAR: begin
        nxt.status = dtcsm_pkg::STATUS_CLEARED;
        nxt.fault  = '0;
        nxt.aging  = '0;
      end
      default: ;
    endcase

    // an item that is not applied leaves the entry as it was
    if (outcome != dtcsm_pkg::OUT_APPLIED) nxt = cur;
  end

  assign mem_we = out_load & (outcome == dtcsm_pkg::OUT_APPLIED);
  assign wdata  = nxt;

  // Output register
  logic [1:0]        outcome_q;
  logic [7:0]        status_q;
  logic [7:0]        avail_q;
  logic signed [7:0] fault_q;
  logic [7:0]        aging_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      outcome_q <= outcome;
      if (in_range_q) begin
        status_q <= nxt.status;
        avail_q  <= nxt.status & avail_mask_q;
        fault_q  <= nxt.fault;
        aging_q  <= nxt.aging;
      end else begin
        status_q <= '0;
        avail_q  <= '0;
        fault_q  <= '0;
        aging_q  <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign status_byte_o      = status_q;
  assign available_status_o = avail_q;
  assign fault_count_o      = fault_q;
  assign aging_count_o      = aging_q;

  // Assertions
  a_xfer_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_CALC) && !in_ready_o)
    else $error("input transfer did not start an update step");

  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> out_load && (state_q == ST_CALC))
    else $error("entry written without a result being loaded");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == dtcsm_pkg::OUT_RANGE) |->
      (status_byte_o == 8'd0) && (fault_count_o == 8'sd0) && (aging_count_o == 8'd0))
    else $error("out of range result carries entry data");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before transfer");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the trouble code status manager.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_ENTRIES = dtcsm_pkg::NumEntriesDefault;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  // One requested operation and one entry view as the block reports it
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic       failed;
  } dtc_op_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] status;
    logic [7:0] avail;
    logic [7:0] fault;
    logic [7:0] aging;
  } entry_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dtcsm_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = dtcsm_pkg::OP_READ;
  logic [7:0] entry_index_i = '0;
  logic test_failed_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] outcome_o;
  logic [7:0] status_byte_o;
  logic [7:0] available_status_o;
  logic signed [7:0] fault_count_o;
  logic [7:0] aging_count_o;

  dtc_status_manager #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .opcode_i(opcode_i),
    .entry_index_i(entry_index_i),
    .test_failed_i(test_failed_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .outcome_o(outcome_o),
    .status_byte_o(status_byte_o),
    .available_status_o(available_status_o),
    .fault_count_o(fault_count_o),
    .aging_count_o(aging_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration registers
  logic              cfg_updates_off;
  logic              cfg_off_exc_batt;
  logic [7:0]        cfg_batt_under;
  logic [7:0]        cfg_batt_over;
  logic [6:0]        cfg_fault_max;
  logic signed [7:0] cfg_fault_min;
  logic [7:0]        cfg_aging_max;
  logic [7:0]        cfg_avail_mask;

  // Shadow of the entry table
  logic [7:0] status_tbl [NUM_ENTRIES];
  logic signed [7:0] fault_tbl [NUM_ENTRIES];
  logic [7:0] aging_tbl [NUM_ENTRIES];

  dtc_op_t     op_requests [$];
  entry_view_t predicted_views [$];

  int  mismatches = 0;
  int  views_checked = 0;
  int  n_applied = 0;
  int  n_range = 0;
  int  n_blocked = 0;
  int  settings_loaded = 0;
  int  hot_entries [4];
  bit  hold_req = 1'b0;
  bit  tail_quiet = 1'b0;

  // Applies one operation to the shadow table and returns the entry view
  function automatic entry_view_t apply_dtc_op(input dtc_op_t o);
    entry_view_t v;
    logic [7:0] st;
    logic blocked;
    int i;
    int cnt;
    int fmax;
    int fmin;
    v = '0;
    i = o.idx;
    blocked = (o.op == dtcsm_pkg::OP_REPORT) && (cfg_updates_off ||
              (cfg_off_exc_batt && o.idx != cfg_batt_under && o.idx != cfg_batt_over));
    if (blocked) begin
      v.outcome = dtcsm_pkg::OUT_BLOCKED;
      n_blocked++;
    end else if (i >= NUM_ENTRIES) begin
      v.outcome = dtcsm_pkg::OUT_RANGE;
      n_range++;
    end else begin
      v.outcome = dtcsm_pkg::OUT_APPLIED;
      n_applied++;
      st = status_tbl[i];
      cnt = fault_tbl[i];
      case (o.op)
        dtcsm_pkg::OP_REPORT: begin
          if (o.failed) begin
            fmax = cfg_fault_max;
            if (cnt < fmax) begin
              cnt = (cnt < 0) ? 1 : ((cnt + 2 > 127) ? 127 : cnt + 2);
              if (cnt >= fmax) begin
                st[dtcsm_pkg::StTf] = 1'b1;
                st[dtcsm_pkg::StTftoc] = 1'b1;
                st[dtcsm_pkg::StPend] = 1'b1;
                st[dtcsm_pkg::StConf] = 1'b1;
                st[dtcsm_pkg::StTfslc] = 1'b1;
                st[dtcsm_pkg::StTnclc] = 1'b0;
                st[dtcsm_pkg::StTnctoc] = 1'b0;
              end
            end
          end else begin
            fmin = cfg_fault_min;
            if (cnt > fmin) begin
              cnt = cnt - 1;
              if (cnt <= fmin) begin
                st[dtcsm_pkg::StTf] = 1'b0;
                st[dtcsm_pkg::StTnclc] = 1'b0;
                st[dtcsm_pkg::StTnctoc] = 1'b0;
              end
            end
          end
          status_tbl[i] = st;
          fault_tbl[i] = 8'(cnt);
        end
        dtcsm_pkg::OP_CYCLE: begin
          if (!st[dtcsm_pkg::StTftoc]) begin
            st[dtcsm_pkg::StPend] = 1'b0;
            if (aging_tbl[i] < cfg_aging_max) aging_tbl[i] = aging_tbl[i] + 8'd1;
            else st[dtcsm_pkg::StConf] = 1'b0;
          end else begin
            aging_tbl[i] = '0;
          end
          st[dtcsm_pkg::StTftoc] = 1'b0;
          st[dtcsm_pkg::StTnctoc] = 1'b1;
          status_tbl[i] = st;
          fault_tbl[i] = '0;
        end
        dtcsm_pkg::OP_CLEAR: begin
          status_tbl[i] = dtcsm_pkg::STATUS_CLEARED;
          fault_tbl[i] = '0;
          aging_tbl[i] = '0;
        end
        default: ;
      endcase
    end
    if (i < NUM_ENTRIES) begin
      v.status = status_tbl[i];
      v.avail = status_tbl[i] & cfg_avail_mask;
      v.fault = fault_tbl[i];
      v.aging = aging_tbl[i];
    end
    return v;
  endfunction

  // Input driver: offers queued operations with random idle bursts
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin : drive
      logic keep;
      dtc_op_t nxt;
      keep = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predicted_views.push_back(apply_dtc_op('{opcode_i, entry_index_i, test_failed_i}));
      end
      if (!keep) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (op_requests.size() > 0) begin
          if (!tail_quiet && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 3);
          end else begin
            nxt = op_requests.pop_front();
            opcode_i <= nxt.op;
            entry_index_i <= nxt.idx;
            test_failed_i <= nxt.failed;
            keep = 1'b1;
          end
        end
      end
      in_valid_i <= keep;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 80;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic log_mismatch(input string what, input entry_view_t want,
                              input entry_view_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected outcome=%0d status=%02h avail=%02h fault=%0d aging=%0d",
               $realtime, what, want.outcome, want.status, want.avail,
               $signed(want.fault), want.aging);
      $display("[%0t] %s:   actual outcome=%0d status=%02h avail=%02h fault=%0d aging=%0d",
               $realtime, what, got.outcome, got.status, got.avail,
               $signed(got.fault), got.aging);
    end
  endtask

  // Result monitor: each transfer is checked against the oldest prediction
  always @(posedge clk_i) begin : monitor
    entry_view_t got;
    entry_view_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got = '{outcome_o, status_byte_o, available_status_o, fault_count_o, aging_count_o};
      if (predicted_views.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = predicted_views.pop_front();
        views_checked++;
        if (got !== want) log_mismatch("entry view mismatch", want, got);
      end
    end
  end

  task automatic push_op(input logic [1:0] op, input logic [7:0] idx, input logic failed);
    op_requests.push_back('{op, idx, failed});
  endtask

  // Waits until every queued operation has produced its result
  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_requests.size() != 0 || in_valid_i || predicted_views.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [dtcsm_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      dtcsm_pkg::REG_UPDATES_OFF:  cfg_updates_off = val[0];
      dtcsm_pkg::REG_OFF_EXC_BATT: cfg_off_exc_batt = val[0];
      dtcsm_pkg::REG_BATT_UNDER:   cfg_batt_under = val;
      dtcsm_pkg::REG_BATT_OVER:    cfg_batt_over = val;
      dtcsm_pkg::REG_FAULT_MAX:    cfg_fault_max = val[6:0];
      dtcsm_pkg::REG_FAULT_MIN:    cfg_fault_min = val;
      dtcsm_pkg::REG_AGING_MAX:    cfg_aging_max = val;
      default:                     cfg_avail_mask = val;
    endcase
  endtask

  // Loads all registers; unused upper bits carry random junk
  task automatic load_setting(input logic uo, input logic oeb, input logic [7:0] bu,
                              input logic [7:0] bo, input logic [6:0] fmax,
                              input logic [7:0] fmin, input logic [7:0] amax,
                              input logic [7:0] mask);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_write(dtcsm_pkg::REG_UPDATES_OFF, {junk[7:1], uo});
    cfg_write(dtcsm_pkg::REG_OFF_EXC_BATT, {junk[6:0], oeb});
    cfg_write(dtcsm_pkg::REG_BATT_UNDER, bu);
    cfg_write(dtcsm_pkg::REG_BATT_OVER, bo);
    cfg_write(dtcsm_pkg::REG_FAULT_MAX, {junk[3], fmax});
    cfg_write(dtcsm_pkg::REG_FAULT_MIN, fmin);
    cfg_write(dtcsm_pkg::REG_AGING_MAX, amax);
    cfg_write(dtcsm_pkg::REG_AVAIL_MASK, mask);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Random traffic: mostly report runs and cycle starts on a few hot entries
  task automatic queue_random_ops(input int count, input int max_run);
    int pushed;
    int kind;
    int run;
    int pick;
    logic lean;
    logic [7:0] idx;
    pushed = 0;
    hot_entries[0] = cfg_batt_under % NUM_ENTRIES;
    hot_entries[1] = cfg_batt_over % NUM_ENTRIES;
    hot_entries[2] = $urandom_range(0, NUM_ENTRIES - 1);
    hot_entries[3] = $urandom_range(0, NUM_ENTRIES - 1);
    while (pushed < count) begin
      kind = $urandom_range(0, 99);
      idx = 8'(hot_entries[$urandom_range(0, 3)]);
      if (kind < 55) begin
        lean = 1'($urandom);
        run = $urandom_range(1, max_run);
        for (int k = 0; k < run && pushed < count; k++) begin
          push_op(dtcsm_pkg::OP_REPORT, idx, ($urandom_range(0, 19) == 0) ? !lean : lean);
          pushed++;
        end
      end else begin
        if (kind < 70) begin
          push_op(dtcsm_pkg::OP_CYCLE, idx, 1'($urandom));
        end else if (kind < 75) begin
          push_op(dtcsm_pkg::OP_CLEAR, 8'($urandom_range(0, NUM_ENTRIES - 1)),
                  1'($urandom));
        end else if (kind < 85) begin
          pick = $urandom_range(0, 1);
          push_op(dtcsm_pkg::OP_READ, pick ? idx : 8'($urandom), 1'($urandom));
        end else begin
          push_op(2'($urandom), 8'($urandom), 1'($urandom));
        end
        pushed++;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    cfg_updates_off = 1'b0;
    cfg_off_exc_batt = 1'b0;
    cfg_batt_under = 8'd0;
    cfg_batt_over = 8'd1;
    cfg_fault_max = 7'd127;
    cfg_fault_min = -8'sd128;
    cfg_aging_max = 8'd40;
    cfg_avail_mask = 8'hFF;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      status_tbl[i] = dtcsm_pkg::STATUS_CLEARED;
      fault_tbl[i] = '0;
      aging_tbl[i] = dtcsm_pkg::AGING_AT_RESET;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset contents, range edges and every operation with reset settings
    push_op(dtcsm_pkg::OP_READ, 8'd0, 1'b0);
    push_op(dtcsm_pkg::OP_READ, 8'd31, 1'b1);
    push_op(dtcsm_pkg::OP_READ, 8'd32, 1'b0);
    push_op(dtcsm_pkg::OP_READ, 8'd255, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd5, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd5, 1'b0);
    push_op(dtcsm_pkg::OP_CYCLE, 8'd5, 1'b1);
    push_op(dtcsm_pkg::OP_CLEAR, 8'd5, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd255, 1'b0);
    wait_drained();

    // Low thresholds: confirm, age out, pass threshold, failed from negative
    load_setting(1'b0, 1'b0, 8'd0, 8'd1, 7'd3, 8'hFE, 8'd2, 8'h0F);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b1);
    push_op(dtcsm_pkg::OP_CYCLE, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd3, 1'b1);
    push_op(dtcsm_pkg::OP_CYCLE, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_CYCLE, 8'd3, 1'b0);
    push_op(dtcsm_pkg::OP_CYCLE, 8'd3, 1'b0);
    wait_drained();

    // All reports disabled: blocked in range and out of range
    load_setting(1'b1, 1'b0, 8'd0, 8'd1, 7'd3, 8'hFE, 8'd2, 8'hFF);
    push_op(dtcsm_pkg::OP_REPORT, 8'd2, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd200, 1'b0);
    push_op(dtcsm_pkg::OP_READ, 8'd2, 1'b0);
    wait_drained();

    // Battery entries only; the overvoltage index is out of range
    load_setting(1'b0, 1'b1, 8'd7, 8'd40, 7'd3, 8'hFE, 8'd2, 8'hFF);
    push_op(dtcsm_pkg::OP_REPORT, 8'd7, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd8, 1'b1);
    push_op(dtcsm_pkg::OP_REPORT, 8'd40, 1'b0);
    push_op(dtcsm_pkg::OP_REPORT, 8'd41, 1'b1);
    wait_drained();

    // Random phases across register extremes
    load_setting(1'b0, 1'b0, 8'd0, 8'd1, 7'd127, 8'h80, 8'd40, 8'hFF);
    queue_random_ops(140, 140);
    wait_drained();

    load_setting(1'b0, 1'b0, 8'd2, 8'd3, 7'd1, 8'h00, 8'd0, 8'hA5);
    queue_random_ops(100, 12);
    wait_drained();

    load_setting(1'b0, 1'b1, 8'd0, 8'd31, 7'd4, 8'hFC, 8'd255, 8'h00);
    queue_random_ops(100, 12);
    wait_drained();

    load_setting(1'b0, 1'b0, 8'd255, 8'd0, 7'd0, 8'hFD, 8'd3, 8'h5A);
    queue_random_ops(100, 12);
    wait_drained();

    load_setting(1'b0, 1'b0, 8'd17, 8'd200, 7'd10, 8'h05, 8'd1, 8'hFF);
    queue_random_ops(100, 12);
    wait_drained();

    load_setting(1'b1, 1'b1, 8'd128, 8'd64, 7'd5, 8'hF0, 8'd7, 8'hC3);
    queue_random_ops(40, 12);
    wait_drained();

    // Receiver holds off while the sender keeps offering
    load_setting(1'b0, 1'b0, 8'd9, 8'd20, 7'd6, 8'hFA, 8'd2, 8'h3C);
    @(posedge clk_i);
    hold_req <= 1'b1;
    queue_random_ops(100, 12);
    wait_drained();

    // Closing stretch with no idling on either side
    load_setting(1'b0, 1'b0, 8'd1, 8'd0, 7'd8, 8'hF8, 8'd4, 8'hFF);
    @(posedge clk_i);
    tail_quiet <= 1'b1;
    queue_random_ops(100, 12);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Coverage: %0d operations (%0d applied, %0d out of range, %0d blocked)",
             n_applied + n_range + n_blocked, n_applied, n_range, n_blocked);
    $display("          over %0d register settings; %0d results compared, %0d mismatches",
             settings_loaded, views_checked, mismatches);
    if (mismatches == 0 && predicted_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending",
             CYCLE_LIMIT, predicted_views.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/dtcsm_pkg.sv
rtl/dtc_status_manager.sv
dv/testbench.sv
